// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the drive command supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define DCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DCS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/dcs_pkg.sv -----
// Shared types and constants of the drive command supervisor.
`default_nettype none

package dcs_pkg;

  // Input word kinds, carried on the slave tuser.
  typedef enum logic [1:0] {
    OP_VEL   = 2'd0,
    OP_MOW   = 2'd1,
    OP_EMERG = 2'd2,
    OP_TICK  = 2'd3
  } dcs_op_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRACK_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MAX_DRIVE     = 2'd1;
  localparam logic [1:0] REG_DRIVE_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FULL_TIMEOUT  = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] TRACK_WIDTH_RST   = 16'd8192;
  localparam logic [10:0] MAX_DRIVE_RST     = 11'd1320;
  localparam logic [15:0] DRIVE_TIMEOUT_RST = 16'd250;
  localparam logic [15:0] FULL_TIMEOUT_RST  = 16'd1250;

  // Blade drive value while mowing.
  localparam logic [10:0] BLADE_ON = 11'd2047;

  // Right shift that takes the scaled mix back to drive units.
  localparam int unsigned MIX_SHIFT = 27;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TURN   = 6'b000010,
    ST_MIXR   = 6'b000100,
    ST_MIXL   = 6'b001000,
    ST_CLAMPL = 6'b010000,
    ST_PUB    = 6'b100000
  } dcs_state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_TURN  = 2'd0,
    MUL_RIGHT = 2'd1,
    MUL_LEFT  = 2'd2
  } dcs_mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         accept;
    logic         mul_en;
    dcs_mul_sel_e mul_sel;
    logic         left_ld;
    logic         publish;
  } dcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dcs_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dcs_ctrl.sv -----
// Controller state machine of the drive command supervisor.
`default_nettype none
`include "assert_macros.svh"

module dcs_ctrl
  import dcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_fire_i,
  input  wire dcs_op_e   op_i,
  input  wire dcs_stat_t stat_i,
  output logic           ready_o,
  output dcs_cmd_t       cmd_o
);

  dcs_state_e state_q, state_d;

  // Next state: a velocity command walks through the multiply steps,
  // emergency requests and ticks go to the publish step.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire_i) begin
          if (op_i == OP_VEL) begin
            state_d = ST_TURN;
          end else if (op_i inside {OP_EMERG, OP_TICK}) begin
            state_d = ST_PUB;
          end
        end
      end
      ST_TURN:   state_d = ST_MIXR;
      ST_MIXR:   state_d = ST_MIXL;
      ST_MIXL:   state_d = ST_CLAMPL;
      ST_CLAMPL: state_d = ST_IDLE;
      ST_PUB: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_TURN;
    cmd_o.accept  = s_fire_i;
    case (state_q)
      ST_TURN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TURN;
      end
      ST_MIXR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RIGHT;
      end
      ST_MIXL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LEFT;
      end
      ST_CLAMPL: cmd_o.left_ld = 1'b1;
      ST_PUB:    cmd_o.publish = stat_i.out_free;
      default:   cmd_o.accept  = s_fire_i;
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);

  `DCS_ASSERT(a_vel_starts_mix, (s_fire_i && op_i == OP_VEL) |=> state_q == ST_TURN,
              "velocity command did not start the mix sequence")
  `DCS_ASSERT(a_pub_waits, (state_q == ST_PUB && !stat_i.out_free) |=> state_q == ST_PUB,
              "publish step left while the output word was still pending")

endmodule

`default_nettype wire

// ----- rtl/core/dcs_datapath.sv -----
// Datapath of the drive command supervisor: registers, shared multiplier,
// clamp, watchdog timer and publish logic.
`default_nettype none
`include "assert_macros.svh"

module dcs_datapath
  import dcs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dcs_cmd_t           cmd_i,
  input  wire dcs_op_e            op_i,
  input  wire logic signed [15:0] linear_speed_i,
  input  wire logic signed [15:0] turn_rate_i,
  input  wire logic               request_flag_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_addr_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [11:0]      left_drive_o,
  output logic signed [11:0]      right_drive_o,
  output logic [10:0]             blade_drive_o,
  output dcs_stat_t               stat_o
);

  localparam int unsigned CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // Truncate a scaled mix toward zero and clamp it to +-lim.
  function automatic logic signed [11:0] clamp_fn(input logic signed [43:0] p,
                                                  input logic [10:0] lim);
    logic signed [43:0] bias;
    logic signed [43:0] biased;
    logic signed [16:0] r;
    logic signed [17:0] rx;
    logic signed [17:0] lx;
    bias   = {17'b0, {MIX_SHIFT{p[43]}}};
    biased = p + bias;
    r      = biased[43:MIX_SHIFT];
    rx     = {r[16], r};
    lx     = {7'b0, lim};
    if (rx >= lx) begin
      return $signed({1'b0, lim});
    end else if (rx <= -lx) begin
      return -$signed({1'b0, lim});
    end else begin
      return r[11:0];
    end
  endfunction

  // Configuration registers.
  logic [15:0] track_q;
  logic [10:0] max_q;
  logic [15:0] dt_q;
  logic [15:0] ft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= TRACK_WIDTH_RST;
      max_q   <= MAX_DRIVE_RST;
      dt_q    <= DRIVE_TIMEOUT_RST;
      ft_q    <= FULL_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TRACK_WIDTH:   track_q <= cfg_wdata_i;
        REG_MAX_DRIVE:     max_q   <= cfg_wdata_i[10:0];
        REG_DRIVE_TIMEOUT: dt_q    <= cfg_wdata_i;
        REG_FULL_TIMEOUT:  ft_q    <= cfg_wdata_i;
        default:           track_q <= track_q;
      endcase
    end
  end

  // Latched velocity command operands.
  logic signed [15:0] v_q;
  logic signed [15:0] w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op_i == OP_VEL) begin
      v_q <= linear_speed_i;
      w_q <= turn_rate_i;
    end
  end

  // Shared multiplier: track width times turn rate, then each mix times max_drive.
  logic signed [31:0] turn_q;
  logic signed [43:0] prod_q;
  logic signed [32:0] lin;
  logic signed [32:0] turn_x;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod_full;

  assign lin    = {{2{v_q[15]}}, v_q, 15'b0};
  assign turn_x = {turn_q[31], turn_q};

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_TURN: begin
        mul_a = {{17{w_q[15]}}, w_q};
        mul_b = $signed({1'b0, track_q});
      end
      MUL_RIGHT: begin
        mul_a = lin + turn_x;
        mul_b = $signed({6'b0, max_q});
      end
      MUL_LEFT: begin
        mul_a = lin - turn_x;
        mul_b = $signed({6'b0, max_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel == MUL_TURN) begin
        turn_q <= prod_full[31:0];
      end else begin
        prod_q <= prod_full[43:0];
      end
    end
  end

  // Held speeds, watchdog timer, emergency flag and last sent triple.
  logic signed [11:0]     left_q, right_q;
  logic [10:0]            blade_q;
  logic [TIMER_WIDTH-1:0] idle_q;
  logic                   emerg_q;
  logic signed [11:0]     sent_left_q, sent_right_q;
  logic [10:0]            sent_blade_q;
  logic                   valid_q;

  // Publish view: forced values under emergency or timeout.
  logic               dt_hit, ft_hit, kill_wheel, kill_blade, differ;
  logic signed [11:0] pub_left, pub_right;
  logic [10:0]        pub_blade;

  always_comb begin
    dt_hit     = CMP_W'(idle_q) > CMP_W'(dt_q);
    ft_hit     = CMP_W'(idle_q) > CMP_W'(ft_q);
    kill_wheel = emerg_q | dt_hit | ft_hit;
    kill_blade = emerg_q | ft_hit;
    pub_left   = kill_wheel ? 12'sd0 : left_q;
    pub_right  = kill_wheel ? 12'sd0 : right_q;
    pub_blade  = kill_blade ? 11'd0 : blade_q;
    differ     = (pub_left != sent_left_q) || (pub_right != sent_right_q) ||
                 (pub_blade != sent_blade_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= '0;
      blade_q      <= '0;
      idle_q       <= '1;
      emerg_q      <= 1'b0;
      sent_left_q  <= '0;
      sent_right_q <= '0;
      sent_blade_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      // Item effects at acceptance.
      if (cmd_i.accept) begin
        case (op_i)
          OP_VEL:   idle_q  <= '0;
          OP_MOW:   blade_q <= (request_flag_i && !emerg_q) ? BLADE_ON : 11'd0;
          OP_EMERG: emerg_q <= request_flag_i;
          OP_TICK: begin
            if (idle_q != '1) begin
              idle_q <= TIMER_WIDTH'(idle_q + 1'b1);
            end
          end
          default:  idle_q  <= idle_q;
        endcase
      end

      // Clamped wheel values from the multiply sequence.
      if (cmd_i.mul_en && cmd_i.mul_sel == MUL_LEFT) begin
        right_q <= clamp_fn(prod_q, max_q);
      end
      if (cmd_i.left_ld) begin
        left_q <= clamp_fn(prod_q, max_q);
      end

      // Publish the forced values and record a changed triple.
      if (cmd_i.publish) begin
        left_q  <= pub_left;
        right_q <= pub_right;
        blade_q <= pub_blade;
        if (differ) begin
          sent_left_q  <= pub_left;
          sent_right_q <= pub_right;
          sent_blade_q <= pub_blade;
        end
      end

      // Output word handshake: a new word replaces one taken in the same cycle.
      if (cmd_i.publish && differ) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign left_drive_o    = sent_left_q;
  assign right_drive_o   = sent_right_q;
  assign blade_drive_o   = sent_blade_q;
  assign stat_o.out_free = !valid_q || out_ready_i;

  `DCS_ASSERT(a_word_from_publish, $rose(valid_q) |-> $past(cmd_i.publish),
              "output word raised without a publish step")
  `DCS_ASSERT(a_blade_values, blade_q == 11'd0 || blade_q == BLADE_ON,
              "held blade value is neither off nor full")

endmodule

`default_nettype wire

// ----- rtl/core/drive_command_supervisor_top.sv -----
// Top level of the drive command supervisor.
// Differential-drive mixer with a command watchdog. The slave stream takes
// one word per item, its kind in tuser: a velocity command mixes linear speed
// and turn rate into clamped left and right drive values and restarts the
// watchdog; a mow request sets the blade; an emergency request or a tick
// publishes, forcing drives to zero under emergency or timeout, and a word
// leaves on the master stream only when the triple changed. A mow request is
// handled at acceptance; an emergency request or tick goes through the publish
// step and waits there for the output register to free; a velocity command
// makes three passes through the shared 33 x 17 bit multiplier, then the final
// clamp. Items are taken one at a time; tready is high only while the
// controller is idle. A word waiting at the output blocks emergency requests
// and ticks, also those that produce no word, but not mow or velocity items.
`default_nettype none

module drive_command_supervisor_top
  import dcs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Slave stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // linear_speed[15:0], turn_rate[31:16],
                                          // request_flag[32], zero pad [39:33]
  input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
  // Master stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // left_drive[11:0], right_drive[23:12],
                                          // blade_drive[34:24], zero pad [39:35]
);

  dcs_cmd_t           cmd;
  dcs_stat_t          stat;
  dcs_op_e            op;
  logic               s_fire;
  logic signed [11:0] left_drive, right_drive;
  logic [10:0]        blade_drive;

  assign op     = dcs_op_e'(s_axis_tuser);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  dcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_fire_i (s_fire),
    .op_i     (op),
    .stat_i   (stat),
    .ready_o  (s_axis_tready),
    .cmd_o    (cmd)
  );

  dcs_datapath #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op),
    .linear_speed_i (s_axis_tdata[15:0]),
    .turn_rate_i    (s_axis_tdata[31:16]),
    .request_flag_i (s_axis_tdata[32]),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .left_drive_o   (left_drive),
    .right_drive_o  (right_drive),
    .blade_drive_o  (blade_drive),
    .stat_o         (stat)
  );

  assign m_axis_tdata = {5'b0, blade_drive, right_drive, left_drive};

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the drive command supervisor top level.
`timescale 1ns / 100ps

module tb;
  import dcs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_PCT = 27;

  // One stimulus word and one motor word, as the streams carry them.
  typedef struct packed {
    dcs_op_e     op;
    logic [15:0] lin;
    logic [15:0] turn;
    logic        flag;
  } cmd_word_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] right;
    logic [10:0] blade;
  } drive_word_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = REG_TRACK_WIDTH;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // linear_speed, turn_rate, request_flag, zero pad
  logic [1:0]  s_axis_tuser = OP_VEL;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // left_drive, right_drive, blade_drive, zero pad

  drive_command_supervisor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Mirror of the supervisor: registers, held speeds, last sent triple, watchdog.
  logic [15:0] reg_track = TRACK_WIDTH_RST;
  logic [10:0] reg_maxd = MAX_DRIVE_RST;
  logic [15:0] reg_dto = DRIVE_TIMEOUT_RST;
  logic [15:0] reg_fto = FULL_TIMEOUT_RST;
  logic [15:0] idle_cnt = '1;
  logic [11:0] hold_l = '0;
  logic [11:0] hold_r = '0;
  logic [10:0] hold_blade = '0;
  logic [11:0] last_l = '0;
  logic [11:0] last_r = '0;
  logic [10:0] last_blade = '0;
  logic        estop = 1'b0;

  cmd_word_t   cmd_backlog[$];
  drive_word_t drive_words_due[$];
  cmd_word_t   cmd_on_bus;
  bit          steady = 1'b0;
  int          n_errors = 0;
  int          n_words_out = 0;
  int          n_settings = 0;
  int          n_by_op[4] = '{0, 0, 0, 0};
  int          cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Scale a mixed sum by max_drive, truncate toward zero, clamp to +-max_drive.
  function automatic logic [11:0] scale_clamp(longint sum);
    longint lim;
    longint prod;
    longint q;
    lim = longint'(reg_maxd);
    prod = sum * lim;
    q = (prod < 0) ? -((-prod) >>> MIX_SHIFT) : (prod >>> MIX_SHIFT);
    if (q >= lim) q = lim;
    else if (q <= -lim) q = -lim;
    return q[11:0];
  endfunction

  // Apply the emergency and watchdog overrides, then emit on change only.
  task automatic publish_drives(output bit fires, output drive_word_t w);
    if (estop) begin
      hold_l = '0;
      hold_r = '0;
      hold_blade = '0;
    end
    if (idle_cnt > reg_dto) begin
      hold_l = '0;
      hold_r = '0;
    end
    if (idle_cnt > reg_fto) begin
      hold_l = '0;
      hold_r = '0;
      hold_blade = '0;
    end
    fires = (hold_l != last_l) || (hold_r != last_r) || (hold_blade != last_blade);
    if (fires) begin
      last_l = hold_l;
      last_r = hold_r;
      last_blade = hold_blade;
    end
    w = '{left: last_l, right: last_r, blade: last_blade};
  endtask

  // Advance the mirror by one accepted command and report any motor word.
  task automatic supervise(input cmd_word_t c, output bit fires, output drive_word_t w);
    longint lin_term;
    longint turn_term;
    fires = 1'b0;
    w = '0;
    case (c.op)
      OP_VEL: begin
        lin_term = longint'($signed(c.lin)) * 32768;
        turn_term = longint'(reg_track) * longint'($signed(c.turn));
        hold_r = scale_clamp(lin_term + turn_term);
        hold_l = scale_clamp(lin_term - turn_term);
        idle_cnt = '0;
      end
      OP_MOW: begin
        hold_blade = (c.flag && !estop) ? BLADE_ON : '0;
      end
      OP_EMERG: begin
        estop = c.flag;
        publish_drives(fires, w);
      end
      default: begin
        if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
        publish_drives(fires, w);
      end
    endcase
  endtask

  // Sender: predicts on each accepted word, then offers the next one.
  always @(posedge clk_i) begin : sender_proc
    cmd_word_t   nxt;
    bit          fires;
    drive_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        supervise(cmd_on_bus, fires, w);
        n_by_op[cmd_on_bus.op]++;
        if (fires) drive_words_due.push_back(w);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = cmd_backlog.pop_front();
          cmd_on_bus = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, nxt.flag, nxt.turn, nxt.lin};
          s_axis_tuser <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted motor word against the oldest prediction.
  always @(posedge clk_i) begin : receiver_proc
    drive_word_t got;
    drive_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{left: m_axis_tdata[11:0], right: m_axis_tdata[23:12],
                blade: m_axis_tdata[34:24]};
        n_words_out++;
        if (drive_words_due.size() == 0) begin
          $display("%0t: unexpected word left %0d right %0d blade %0d", $time,
                   $signed(got.left), $signed(got.right), got.blade);
          n_errors++;
        end else begin
          want = drive_words_due.pop_front();
          if (got.left !== want.left) begin
            $display("%0t: left_drive expected %0d got %0d", $time,
                     $signed(want.left), $signed(got.left));
            n_errors++;
          end
          if (got.right !== want.right) begin
            $display("%0t: right_drive expected %0d got %0d", $time,
                     $signed(want.right), $signed(got.right));
            n_errors++;
          end
          if (got.blade !== want.blade) begin
            $display("%0t: blade_drive expected %0d got %0d", $time, want.blade, got.blade);
            n_errors++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still due", $time, drive_words_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cmd_word_t cmd(dcs_op_e op, logic [15:0] lin, logic [15:0] turn,
                                    logic flag);
    return '{op: op, lin: lin, turn: turn, flag: flag};
  endfunction

  // Register write while the block is idle; the mirror follows at once.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_TRACK_WIDTH:   reg_track = val;
      REG_MAX_DRIVE:     reg_maxd = val[10:0];
      REG_DRIVE_TIMEOUT: reg_dto = val;
      default:           reg_fto = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Let every queued word go out and every predicted word come back.
  task automatic drain();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || drive_words_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [15:0] speed_value();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  // Mostly meaningful traffic, with runs of ticks long enough to hit timeouts.
  task automatic queue_random(int count);
    int roll;
    int n;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        cmd_backlog.push_back(cmd(OP_VEL, speed_value(), speed_value(),
                                  1'($urandom_range(0, 1))));
        n++;
      end else if (roll < 37) begin
        cmd_backlog.push_back(cmd(OP_MOW, speed_value(), speed_value(),
                                  1'($urandom_range(0, 3) != 0)));
        n++;
      end else if (roll < 45) begin
        cmd_backlog.push_back(cmd(OP_EMERG, speed_value(), speed_value(),
                                  1'($urandom_range(0, 99) < 35)));
        n++;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          cmd_backlog.push_back(cmd(OP_TICK, speed_value(), speed_value(),
                                    1'($urandom_range(0, 1))));
          n++;
        end
      end
    end
  endtask

  // New random settings, extremes now and then; timeouts short unless asked.
  task automatic random_settings(bit wide_timeouts);
    logic [15:0] dto;
    logic [15:0] fto;
    logic [10:0] maxd;
    case ($urandom_range(0, 7))
      0:       write_reg(REG_TRACK_WIDTH, 16'h0000);
      1:       write_reg(REG_TRACK_WIDTH, 16'hFFFF);
      default: write_reg(REG_TRACK_WIDTH, 16'($urandom_range(0, 65535)));
    endcase
    case ($urandom_range(0, 7))
      0:       maxd = 11'd0;
      1:       maxd = 11'd2047;
      default: maxd = 11'($urandom_range(0, 2047));
    endcase
    write_reg(REG_MAX_DRIVE, {5'($urandom_range(0, 31)), maxd});
    if (wide_timeouts) begin
      dto = 16'($urandom_range(0, 65535));
      fto = 16'($urandom_range(0, 65535));
    end else begin
      dto = 16'($urandom_range(0, 10));
      fto = 16'($urandom_range(0, 30));
    end
    write_reg(REG_DRIVE_TIMEOUT, dto);
    write_reg(REG_FULL_TIMEOUT, fto);
    n_settings++;
  endtask

  initial begin : stimulus_proc
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Largest settings; the timer is still saturated from reset, and a timeout at
    // the saturation value never fires, so the blade can come on by a tick alone.
    write_reg(REG_TRACK_WIDTH, 16'hFFFF);
    write_reg(REG_MAX_DRIVE, 16'h07FF);
    write_reg(REG_DRIVE_TIMEOUT, 16'hFFFF);
    write_reg(REG_FULL_TIMEOUT, 16'hFFFF);
    n_settings++;
    @(negedge clk_i);
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_MOW, 16'h0000, 16'h0000, 1'b1));
    cmd_backlog.push_back(cmd(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h7FFF, 16'h7FFF, 1'b0));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h8000, 16'h8000, 1'b1));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h8000, 16'h7FFF, 1'b0));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h7FFF, 16'h8000, 1'b0));
    // Emergency: zeroes at once, blocks the blade, still takes velocity commands.
    cmd_backlog.push_back(cmd(OP_EMERG, 16'h0000, 16'h0000, 1'b1));
    cmd_backlog.push_back(cmd(OP_MOW, 16'h0000, 16'h0000, 1'b1));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h03E8, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_EMERG, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h1000, 16'h0800, 1'b0));
    cmd_backlog.push_back(cmd(OP_MOW, 16'h0000, 16'h0000, 1'b1));
    cmd_backlog.push_back(cmd(OP_EMERG, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    drain();

    // Smallest settings: any tick after a command is already past both timeouts.
    write_reg(REG_TRACK_WIDTH, 16'h0000);
    write_reg(REG_MAX_DRIVE, 16'h0000);
    write_reg(REG_DRIVE_TIMEOUT, 16'h0000);
    write_reg(REG_FULL_TIMEOUT, 16'h0000);
    n_settings++;
    @(negedge clk_i);
    cmd_backlog.push_back(cmd(OP_MOW, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_EMERG, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_VEL, 16'h7FFF, 16'h7FFF, 1'b0));
    cmd_backlog.push_back(cmd(OP_MOW, 16'h0000, 16'h0000, 1'b1));
    cmd_backlog.push_back(cmd(OP_EMERG, 16'h0000, 16'h0000, 1'b0));
    cmd_backlog.push_back(cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0));
    drain();

    // Random phases; the first runs without idling, one uses wide timeouts.
    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 0);
      random_settings(phase == 3);
      @(negedge clk_i);
      queue_random(72);
      drain();
    end
    steady = 1'b0;

    $display("Sent %0d velocity, %0d mow, %0d emergency and %0d tick words",
             n_by_op[OP_VEL], n_by_op[OP_MOW], n_by_op[OP_EMERG], n_by_op[OP_TICK]);
    $display("under %0d register settings; checked %0d motor words.",
             n_settings, n_words_out);
    if (n_errors == 0 && drive_words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
